// ----- src/event_qualifier_rate_limit_queue_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Event qualifier assertion macros
// Shared assertion forms for the event qualifier checker.
// ----------------------------------------------------------------------------
`ifndef EVENT_QUALIFIER_RATE_LIMIT_QUEUE_UNIT_DEFINES_SVH
`define EVENT_QUALIFIER_RATE_LIMIT_QUEUE_UNIT_DEFINES_SVH

// Plain property that must hold at every clock edge outside reset.
`define EQRLQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication that must hold at every clock edge outside reset.
`define EQRLQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication that must hold at every clock edge outside reset.
`define EQRLQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/eqrlq_pkg.sv -----
// ----------------------------------------------------------------------------
// Event qualifier package
// Types, codes and reset values shared by the event qualifier modules.
// ----------------------------------------------------------------------------
package eqrlq_pkg;

  // Default number of queue slots.
  localparam int DEFAULT_QUEUE_DEPTH = 16;

  // Fill count width; the queue limit register caps the fill below 32.
  localparam int CNT_W = 5;

  // Register port widths.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_ZONE    = 2'd0,
    OP_LEADER  = 2'd1,
    OP_TRIGGER = 2'd2,
    OP_POP     = 2'd3
  } opcode_e;

  // Kinds of stored events.
  typedef enum logic [1:0] {
    KIND_ZONE     = 2'd0,
    KIND_LEADER   = 2'd1,
    KIND_EXTERNAL = 2'd2
  } kind_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_QUEUED   = 3'd0,
    ST_DISABLED = 3'd1,
    ST_LOW_CONF = 3'd2,
    ST_PENDING  = 3'd3,
    ST_COOLDOWN = 3'd4,
    ST_POPPED   = 3'd5,
    ST_EMPTY    = 3'd6
  } status_e;

  // Register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_ENABLE         = 3'd0,
    REG_MIN_CONFIDENCE = 3'd1,
    REG_CONFIRM_FRAMES = 3'd2,
    REG_COOLDOWN_MS    = 3'd3,
    REG_QUEUE_LIMIT    = 3'd4
  } reg_idx_e;

  // Register reset values.
  localparam logic        RST_ENABLE         = 1'b1;
  localparam logic [7:0]  RST_MIN_CONFIDENCE = 8'd128;
  localparam logic [7:0]  RST_CONFIRM_FRAMES = 8'd3;
  localparam logic [15:0] RST_COOLDOWN_MS    = 16'd1000;
  localparam logic [4:0]  RST_QUEUE_LIMIT    = 5'd16;

  // One input request.
  typedef struct packed {
    opcode_e            opcode;
    logic [7:0]         confidence;
    logic [3:0]         target_zone;
    logic [31:0]        now_ms;
    logic [31:0]        stamp_ms;
    logic [7:0]         leader_id;
    logic [3:0]         camera_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] speed;
  } item_t;

  // One queued event.
  typedef struct packed {
    kind_e              kind;
    logic [3:0]         zone;
    logic [7:0]         leader;
    logic [3:0]         camera;
    logic [7:0]         confidence;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] speed;
    logic [31:0]        stamp;
  } entry_t;

  // Commands into the event queue, valid for one cycle.
  typedef struct packed {
    logic push;
    logic pop;
  } q_cmd_t;

  // Queue status seen by the qualifier.
  typedef struct packed {
    logic             empty;
    logic             dropped;
    logic [CNT_W-1:0] fill_next;
  } q_stat_t;

endpackage

// ----- src/eqrlq_queue.sv -----
// ----------------------------------------------------------------------------
// Event queue
// Bounded ring of events that drops its oldest entry when the limit is hit.
// ----------------------------------------------------------------------------
module eqrlq_queue #(
  parameter int QUEUE_DEPTH = eqrlq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  eqrlq_pkg::q_cmd_t           cmd_i,
  input  eqrlq_pkg::entry_t           entry_i,
  input  logic [eqrlq_pkg::CNT_W-1:0] limit_i,
  output eqrlq_pkg::entry_t           head_o,
  output eqrlq_pkg::q_stat_t          stat_o
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SUM_W = $clog2(2 * QUEUE_DEPTH) + 1;

  logic [IDX_W-1:0]            head_q, head_d;
  logic [eqrlq_pkg::CNT_W-1:0] fill_q, fill_d;
  logic [eqrlq_pkg::CNT_W-1:0] lim;
  logic [SUM_W-1:0]            tail_sum;
  logic [IDX_W-1:0]            tail;
  logic [IDX_W-1:0]            head_inc;
  logic                        empty;
  logic                        do_pop;
  logic                        drop;

  eqrlq_pkg::entry_t mem_q [QUEUE_DEPTH];
  eqrlq_pkg::entry_t rd_q;

  // Effective limit: zero acts as one, anything above the depth as the depth.
  always_comb begin
    if (limit_i == '0) begin
      lim = eqrlq_pkg::CNT_W'(1);
    end else if (int'(limit_i) > QUEUE_DEPTH) begin
      lim = eqrlq_pkg::CNT_W'(QUEUE_DEPTH);
    end else begin
      lim = limit_i;
    end
  end

  assign empty  = (fill_q == '0);
  assign do_pop = cmd_i.pop && !empty;
  assign drop   = cmd_i.push && (fill_q >= lim);

  assign head_inc = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

  // The tail slot sits fill entries after the head; a drop moves the head on
  // while the push that caused it keeps the fill, so the tail moves on as well.
  always_comb begin
    tail_sum = SUM_W'(head_q) + SUM_W'(fill_q);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
    end
    tail = tail_sum[IDX_W-1:0];
  end

  // Head and fill updates.
  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (do_pop || drop) begin
      head_d = head_inc;
    end
    if (do_pop) begin
      fill_d = fill_q - 1'b1;
    end else if (cmd_i.push && !drop) begin
      fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  // Event storage; the read port always fetches the next head entry so that
  // the following request finds it registered, with a bypass for a write to
  // that same slot.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[tail] <= entry_i;
    end
    if (cmd_i.push && (tail == head_d)) begin
      rd_q <= entry_i;
    end else begin
      rd_q <= mem_q[head_d];
    end
  end

  assign head_o            = rd_q;
  assign stat_o.empty      = empty;
  assign stat_o.dropped    = drop;
  assign stat_o.fill_next  = fill_d;

endmodule

// ----- src/event_qualifier_rate_limit_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Event qualifier with rate limit and event queue
// Qualifies zone, leader and trigger requests and queues the events that pass.
//
// Every request yields exactly one result. A request is taken into an input
// register, qualified in the next cycle against the confidence threshold, the
// zone confirmation counter and the per-kind cooldown, and its result lands in
// an output register; the block takes one request per clock as long as the
// result side keeps up. Events that pass go into a ring of QUEUE_DEPTH slots,
// bounded by the queue_limit register, that drops its oldest entry when full.
// The ring memory is read ahead into a register at the next head slot, which
// lets a pop follow any request back to back. Registers are to be written over
// the APB port only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module event_qualifier_rate_limit_queue_unit #(
  parameter int QUEUE_DEPTH = eqrlq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Register port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [eqrlq_pkg::ADDR_W-1:0] paddr,
  input  logic [eqrlq_pkg::DATA_W-1:0] pwdata,
  output logic [eqrlq_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  // Request channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   opcode_i,
  input  logic [7:0]                   confidence_i,
  input  logic [3:0]                   target_zone_i,
  input  logic [31:0]                  now_ms_i,
  input  logic [31:0]                  stamp_ms_i,
  input  logic [7:0]                   leader_id_i,
  input  logic [3:0]                   camera_id_i,
  input  logic signed [15:0]           pos_x_i,
  input  logic signed [15:0]           pos_y_i,
  input  logic signed [15:0]           speed_i,
  // Result channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   status_o,
  output logic                         dropped_oldest_o,
  output logic [1:0]                   event_kind_o,
  output logic [3:0]                   event_zone_o,
  output logic [7:0]                   event_leader_o,
  output logic [3:0]                   event_camera_o,
  output logic signed [15:0]           event_x_o,
  output logic signed [15:0]           event_y_o,
  output logic signed [15:0]           event_speed_o,
  output logic [7:0]                   event_confidence_o,
  output logic [31:0]                  event_time_o,
  output logic [4:0]                   queue_count_o
);

  // Configuration registers.
  logic                        enable_q;
  logic [7:0]                  min_conf_q;
  logic [7:0]                  confirm_q;
  logic [15:0]                 cooldown_q;
  logic [eqrlq_pkg::CNT_W-1:0] limit_q;
  logic                        cfg_wr;
  eqrlq_pkg::reg_idx_e         cfg_idx;

  // Request pipeline.
  logic                        in_valid_q;
  eqrlq_pkg::item_t            item_q;
  logic                        accept;
  logic                        adv;

  // Qualifier state.
  logic [3:0]                  pend_q, pend_d;
  logic [7:0]                  cnt_q, cnt_d;
  logic [31:0]                 last_zone_q, last_zone_d;
  logic [31:0]                 last_leader_q, last_leader_d;

  // Qualifier decisions.
  logic                        zone_match;
  logic [7:0]                  cnt_inc;
  logic [7:0]                  cnt_new;
  logic [31:0]                 zone_gap;
  logic [31:0]                 leader_gap;
  logic                        zone_cool;
  logic                        leader_cool;
  logic                        push_req;
  logic                        pop_req;
  eqrlq_pkg::status_e          status;
  eqrlq_pkg::entry_t           push_entry;
  eqrlq_pkg::entry_t           res_entry;

  // Queue interface.
  eqrlq_pkg::q_cmd_t           q_cmd;
  eqrlq_pkg::q_stat_t          q_stat;
  eqrlq_pkg::entry_t           q_head;

  // Result register.
  logic                        out_valid_q;
  eqrlq_pkg::status_e          out_status_q;
  logic                        out_dropped_q;
  eqrlq_pkg::entry_t           out_entry_q;
  logic [eqrlq_pkg::CNT_W-1:0] out_count_q;

  // Register write and read decode.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = eqrlq_pkg::reg_idx_e'(paddr[eqrlq_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= eqrlq_pkg::RST_ENABLE;
      min_conf_q <= eqrlq_pkg::RST_MIN_CONFIDENCE;
      confirm_q  <= eqrlq_pkg::RST_CONFIRM_FRAMES;
      cooldown_q <= eqrlq_pkg::RST_COOLDOWN_MS;
      limit_q    <= eqrlq_pkg::RST_QUEUE_LIMIT;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        eqrlq_pkg::REG_ENABLE:         enable_q   <= pwdata[0];
        eqrlq_pkg::REG_MIN_CONFIDENCE: min_conf_q <= pwdata[7:0];
        eqrlq_pkg::REG_CONFIRM_FRAMES: confirm_q  <= pwdata[7:0];
        eqrlq_pkg::REG_COOLDOWN_MS:    cooldown_q <= pwdata[15:0];
        eqrlq_pkg::REG_QUEUE_LIMIT:    limit_q    <= pwdata[eqrlq_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      eqrlq_pkg::REG_ENABLE:         prdata = eqrlq_pkg::DATA_W'(enable_q);
      eqrlq_pkg::REG_MIN_CONFIDENCE: prdata = eqrlq_pkg::DATA_W'(min_conf_q);
      eqrlq_pkg::REG_CONFIRM_FRAMES: prdata = eqrlq_pkg::DATA_W'(confirm_q);
      eqrlq_pkg::REG_COOLDOWN_MS:    prdata = eqrlq_pkg::DATA_W'(cooldown_q);
      eqrlq_pkg::REG_QUEUE_LIMIT:    prdata = eqrlq_pkg::DATA_W'(limit_q);
      default:                       prdata = '0;
    endcase
  end

  // Handshake: the input register moves on whenever the result register is
  // free or being emptied in this cycle.
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.opcode      <= eqrlq_pkg::opcode_e'(opcode_i);
      item_q.confidence  <= confidence_i;
      item_q.target_zone <= target_zone_i;
      item_q.now_ms      <= now_ms_i;
      item_q.stamp_ms    <= stamp_ms_i;
      item_q.leader_id   <= leader_id_i;
      item_q.camera_id   <= camera_id_i;
      item_q.pos_x       <= pos_x_i;
      item_q.pos_y       <= pos_y_i;
      item_q.speed       <= speed_i;
    end
  end

  // Zone confirmation counter, saturating at its top value.
  assign zone_match = (item_q.target_zone == pend_q);
  assign cnt_inc    = (cnt_q != 8'hFF) ? cnt_q + 8'd1 : cnt_q;
  assign cnt_new    = zone_match ? cnt_inc : 8'd1;

  // Cooldown checks use wrapping time differences.
  assign zone_gap    = item_q.now_ms - last_zone_q;
  assign leader_gap  = item_q.now_ms - last_leader_q;
  assign zone_cool   = (zone_gap < {16'd0, cooldown_q});
  assign leader_cool = (leader_gap < {16'd0, cooldown_q});

  // Request qualification.
  always_comb begin
    status        = eqrlq_pkg::ST_QUEUED;
    push_req      = 1'b0;
    pop_req       = 1'b0;
    push_entry    = '0;
    pend_d        = pend_q;
    cnt_d         = cnt_q;
    last_zone_d   = last_zone_q;
    last_leader_d = last_leader_q;

    if (item_q.opcode == eqrlq_pkg::OP_POP) begin
      if (q_stat.empty) begin
        status = eqrlq_pkg::ST_EMPTY;
      end else begin
        status  = eqrlq_pkg::ST_POPPED;
        pop_req = 1'b1;
      end
    end else if (!enable_q) begin
      status = eqrlq_pkg::ST_DISABLED;
    end else if (item_q.opcode == eqrlq_pkg::OP_TRIGGER) begin
      push_req         = 1'b1;
      push_entry.kind  = eqrlq_pkg::KIND_EXTERNAL;
      push_entry.stamp = item_q.now_ms;
    end else if (item_q.confidence < min_conf_q) begin
      status = eqrlq_pkg::ST_LOW_CONF;
    end else if (item_q.opcode == eqrlq_pkg::OP_ZONE) begin
      pend_d = item_q.target_zone;
      cnt_d  = cnt_new;
      if (cnt_new < confirm_q) begin
        status = eqrlq_pkg::ST_PENDING;
      end else if (zone_cool) begin
        status = eqrlq_pkg::ST_COOLDOWN;
      end else begin
        push_req              = 1'b1;
        push_entry.kind       = eqrlq_pkg::KIND_ZONE;
        push_entry.zone       = item_q.target_zone;
        push_entry.confidence = item_q.confidence;
        push_entry.pos_x      = item_q.pos_x;
        push_entry.stamp      = item_q.stamp_ms;
        last_zone_d           = item_q.stamp_ms;
        pend_d                = '0;
        cnt_d                 = '0;
      end
    end else begin
      if (leader_cool) begin
        status = eqrlq_pkg::ST_COOLDOWN;
      end else begin
        push_req              = 1'b1;
        push_entry.kind       = eqrlq_pkg::KIND_LEADER;
        push_entry.leader     = item_q.leader_id;
        push_entry.camera     = item_q.camera_id;
        push_entry.confidence = item_q.confidence;
        push_entry.pos_x      = item_q.pos_x;
        push_entry.pos_y      = item_q.pos_y;
        push_entry.speed      = item_q.speed;
        push_entry.stamp      = item_q.now_ms;
        last_leader_d         = item_q.now_ms;
      end
    end
  end

  // Qualifier state commits only when the request moves to the result side.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q        <= '0;
      cnt_q         <= '0;
      last_zone_q   <= '0;
      last_leader_q <= '0;
    end else if (adv) begin
      pend_q        <= pend_d;
      cnt_q         <= cnt_d;
      last_zone_q   <= last_zone_d;
      last_leader_q <= last_leader_d;
    end
  end

  // Event queue.
  assign q_cmd.push = adv && push_req;
  assign q_cmd.pop  = adv && pop_req;

  eqrlq_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (q_cmd),
    .entry_i (push_entry),
    .limit_i (limit_q),
    .head_o  (q_head),
    .stat_o  (q_stat)
  );

  // Event fields are zero unless an entry was popped.
  assign res_entry = pop_req ? q_head : '0;

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_status_q  <= status;
      out_dropped_q <= q_stat.dropped;
      out_entry_q   <= res_entry;
      out_count_q   <= q_stat.fill_next;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign dropped_oldest_o   = out_dropped_q;
  assign event_kind_o       = out_entry_q.kind;
  assign event_zone_o       = out_entry_q.zone;
  assign event_leader_o     = out_entry_q.leader;
  assign event_camera_o     = out_entry_q.camera;
  assign event_x_o          = out_entry_q.pos_x;
  assign event_y_o          = out_entry_q.pos_y;
  assign event_speed_o      = out_entry_q.speed;
  assign event_confidence_o = out_entry_q.confidence;
  assign event_time_o       = out_entry_q.stamp;
  assign queue_count_o      = out_count_q;

endmodule

// ----- src/eqrlq_checker.sv -----
// ----------------------------------------------------------------------------
// Event qualifier checker
// Port-level checks on the results of the event qualifier.
// ----------------------------------------------------------------------------
`include "event_qualifier_rate_limit_queue_unit_defines.svh"

module eqrlq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [2:0]                   status_o,
  input logic                         dropped_oldest_o,
  input logic [1:0]                   event_kind_o,
  input logic [3:0]                   event_zone_o,
  input logic [7:0]                   event_leader_o,
  input logic [3:0]                   event_camera_o,
  input logic signed [15:0]           event_x_o,
  input logic signed [15:0]           event_y_o,
  input logic signed [15:0]           event_speed_o,
  input logic [7:0]                   event_confidence_o,
  input logic [31:0]                  event_time_o,
  input logic [4:0]                   queue_count_o
);

  logic popped;
  logic no_event;

  assign popped   = (status_o == 3'(eqrlq_pkg::ST_POPPED));
  assign no_event = (event_kind_o == '0) && (event_zone_o == '0) &&
                    (event_leader_o == '0) && (event_camera_o == '0) &&
                    (event_x_o == '0) && (event_y_o == '0) &&
                    (event_speed_o == '0) && (event_confidence_o == '0) &&
                    (event_time_o == '0);

  // A stalled result keeps its valid and its status.
  `EQRLQ_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o), "stalled result changed")

  // Only a pop carries event fields.
  `EQRLQ_ASSERT_IMPL(a_event_zero, clk_i, rst_ni, out_valid_o && !popped, no_event, "event fields set without a pop")

  // Only a queued event can push out the oldest entry.
  `EQRLQ_ASSERT_IMPL(a_drop_queued, clk_i, rst_ni, out_valid_o && dropped_oldest_o, status_o == 3'(eqrlq_pkg::ST_QUEUED), "drop reported without a queued event")

  // An empty pop reports an empty queue.
  `EQRLQ_ASSERT_IMPL(a_empty_count, clk_i, rst_ni, out_valid_o && (status_o == 3'(eqrlq_pkg::ST_EMPTY)), queue_count_o == '0, "empty pop with a nonzero count")

endmodule

bind event_qualifier_rate_limit_queue_unit eqrlq_checker u_eqrlq_checker (.*);
